// ----- rtl/tlbf_pkg.sv -----
// shared types and constants for the process-tagged tlb
// no dependencies
package tlbf_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int ADDR_W         = 32;
    localparam int PAGE_W         = 20;
    localparam int FRAME_W        = 20;
    localparam int OWNER_W        = 16;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    // classified request as it travels from front to back
    typedef struct packed {
        op_t                op;
        logic [OWNER_W-1:0] owner;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PICK,
        ST_DONE
    } back_state_t;

endpackage

// ----- rtl/tlbf_front.sv -----
// front end: takes request items and turns them into commands
// depends on tlbf_pkg
module tlbf_front
    import tlbf_pkg::*;
#(
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         req_type,
    input  logic [OWNER_W-1:0] proc_id,
    input  logic [ADDR_W-1:0]  virt_address,
    input  logic [PAGE_W-1:0]  page_number,
    input  logic [FRAME_W-1:0] new_frame,
    output logic               push_valid,
    input  logic               push_ready,
    output cmd_t               push_cmd
);

    logic [ADDR_W-1:0] addr_shifted;

    assign addr_shifted = virt_address >> PAGE_SHIFT;

    always_comb begin
        push_cmd.op    = op_t'(req_type);
        push_cmd.owner = proc_id;
        push_cmd.frame = new_frame;
        // lookups take their page from the address, remove and insert carry it
        if (op_t'(req_type) == OP_LOOKUP) begin
            push_cmd.page = addr_shifted[PAGE_W-1:0];
        end else begin
            push_cmd.page = page_number;
        end
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

// ----- rtl/tlbf_queue.sv -----
// short command queue between front and back
// depends on tlbf_pkg
module tlbf_queue
    import tlbf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  cmd_t      push_cmd,
    output logic      pop_valid,
    input  logic      pop_ready,
    output cmd_t      pop_cmd,
    output q_status_t status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push_ready   = !status.full;
    assign pop_valid    = !status.empty;
    assign pop_cmd      = slot_reg[rd_ptr_reg];
    assign do_push      = push_valid && push_ready;
    assign do_pop       = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/tlbf_back.sv -----
// back end: entry store, associative match, fifo replacement, result register
// depends on tlbf_pkg
module tlbf_back
    import tlbf_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd_in,
    output logic               res_valid,
    input  logic               res_ready,
    output logic               res_hit,
    output logic [FRAME_W-1:0] res_frame
);

    localparam int IDX_W = $clog2(ENTRIES);

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [PAGE_W-1:0]  page_reg  [ENTRIES];
    logic [OWNER_W-1:0] owner_reg [ENTRIES];
    logic [FRAME_W-1:0] frame_mem [ENTRIES];
    logic [FRAME_W-1:0] rd_frame_reg;
    logic [ENTRIES-1:0] match_vec, match_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   victim_reg;
    logic [IDX_W-1:0]   pick_idx;
    logic               found;
    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic               take_cmd, out_load;
    logic               do_insert, do_remove, do_flush, do_read;

    // owner and page compare against every entry
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = valid_reg[i] && (owner_reg[i] == cmd_reg.owner)
                           && (page_reg[i] == cmd_reg.page);
        end
    end

    // lowest index wins
    always_comb begin
        pick_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                pick_idx = IDX_W'(i);
            end
        end
    end
    assign found = |match_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (cmd_valid) state_next = ST_MATCH;
            ST_MATCH: state_next = ST_PICK;
            ST_PICK:  state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd_ready = 1'b0;
        do_insert = 1'b0;
        do_remove = 1'b0;
        do_flush  = 1'b0;
        do_read   = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: cmd_ready = 1'b1;
            ST_MATCH: ;
            ST_PICK: begin
                do_insert = (cmd_reg.op == OP_INSERT);
                do_remove = (cmd_reg.op == OP_REMOVE) && found;
                do_flush  = (cmd_reg.op == OP_FLUSH);
                do_read   = (cmd_reg.op == OP_LOOKUP);
            end
            ST_DONE: out_load = !out_valid_reg || res_ready;
            default: ;
        endcase
    end

    assign take_cmd = cmd_valid && cmd_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (res_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            victim_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (do_flush) begin
                valid_reg <= '0;
            end else if (do_insert) begin
                valid_reg[victim_reg] <= 1'b1;
            end else if (do_remove) begin
                valid_reg[pick_idx] <= 1'b0;
            end
            if (do_insert) begin
                victim_reg <= (victim_reg == IDX_W'(ENTRIES - 1)) ? '0 : victim_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_cmd) begin
            cmd_reg <= cmd_in;
        end
        if (state_reg == ST_MATCH) begin
            match_reg <= match_vec;
        end
        if (state_reg == ST_PICK) begin
            hit_reg <= found && (cmd_reg.op == OP_LOOKUP);
        end
        if (do_insert) begin
            page_reg[victim_reg]  <= cmd_reg.page;
            owner_reg[victim_reg] <= cmd_reg.owner;
        end
        if (out_load) begin
            out_hit_reg   <= hit_reg;
            out_frame_reg <= hit_reg ? rd_frame_reg : '0;
        end
    end

    // frame store, one port
    always_ff @(posedge aclk) begin
        if (do_insert) begin
            frame_mem[victim_reg] <= cmd_reg.frame;
        end
        if (do_read) begin
            rd_frame_reg <= frame_mem[pick_idx];
        end
    end

    assign res_valid = out_valid_reg;
    assign res_hit   = out_hit_reg;
    assign res_frame = out_frame_reg;

endmodule

// ----- rtl/fifo_tagged_tlb_top.sv -----
// top level of the process-tagged, fully associative tlb with fifo replacement
// depends on tlbf_pkg, tlbf_front, tlbf_queue, tlbf_back
//
//  channel  dir  handshake          tuser           tdata
//  s_       in   s_tvalid/s_tready  [1:0] req_type  [15:0] proc_id, [47:16] virt_address,
//                                                   [67:48] page_number, [87:68] new_frame
//  m_       out  m_tvalid/m_tready  [0] hit         [19:0] frame_out, [23:20] zero
//
// each item passes through the back end in steps: pop, associative compare, lowest-match
// pick with entry update or frame read, and loading of the result register
// the front takes an item whenever the two-item queue has room, so the input side
// keeps moving while a result waits on m_tready
// a stall on m_tready holds the back end in its last step and the result register
// aresetn (synchronous) invalidates all entries, zeroes the victim pointer, empties the queue
module fifo_tagged_tlb_top
    import tlbf_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    input  logic [87:0] s_tdata,   // proc_id, virt_address, page_number, new_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [0:0]  m_tuser,   // [0] hit
    output logic [23:0] m_tdata    // [19:0] frame_out, upper bits zero
);

    logic               push_valid, push_ready;
    cmd_t               push_cmd;
    logic               pop_valid, pop_ready;
    cmd_t               pop_cmd;
    q_status_t          q_status;
    logic [FRAME_W-1:0] res_frame;

    // request decode and page selection
    tlbf_front #(
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .req_type     (s_tuser),
        .proc_id      (s_tdata[15:0]),
        .virt_address (s_tdata[47:16]),
        .page_number  (s_tdata[67:48]),
        .new_frame    (s_tdata[87:68]),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    // decouples the input side from the entry store
    tlbf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .status     (q_status)
    );

    // entry store and replacement
    tlbf_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd_in    (pop_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_hit   (m_tuser[0]),
        .res_frame (res_frame)
    );

    assign m_tdata = {4'b0000, res_frame};

    // a miss or a non-lookup item never reports a frame
    a_frame_zero_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 24'd0))
        else $error("frame reported without a hit");

    // queue cannot be empty and full together
    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.empty && q_status.full))
        else $error("queue status inconsistent");

    // an item taken by the back end leaves the queue non-full next cycle
    a_pop_frees_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready && !(push_valid && push_ready)) |=> !q_status.full)
        else $error("queue full after pop");

endmodule

// ----- dv/fifo_tagged_tlb_top_tb.sv -----
// self-checking testbench for fifo_tagged_tlb_top: directed table, then random requests
// depends on tlbf_pkg and the rtl under rtl/, checks each result against its predictor or table
module fifo_tagged_tlb_top_tb;
    import tlbf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS     = ENTRIES_DEF;
    localparam int N_ITEMS     = 1950;
    localparam int N_DIRECTED  = 24;
    localparam int PRESSURE_AT = 400;     // accepted items before the long receiver hold-off
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 20;

    // one request as the stimulus sees it, with an optional hand-written result
    typedef struct {
        op_t                op;
        logic [OWNER_W-1:0] owner;
        logic [ADDR_W-1:0]  addr;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        bit                 fixed;      // want_* typed in by hand, predictor result not used
        bit                 want_hit;
        logic [FRAME_W-1:0] want_frame;
    } tlb_req_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } xlat_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser  = '0;
    logic [87:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [0:0]  m_tuser;
    logic [23:0] m_tdata;

    fifo_tagged_tlb_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // predictor copy of the tlb contents
    logic [PAGE_W-1:0]  tlb_page  [N_SLOTS];
    logic [FRAME_W-1:0] tlb_frame [N_SLOTS];
    logic [OWNER_W-1:0] tlb_owner [N_SLOTS];
    bit                 tlb_valid [N_SLOTS];
    int                 victim_slot;

    xlat_t    expected_xlat_q[$];
    tlb_req_t cur_req;                  // item currently offered on the input side
    tlb_req_t directed_tbl [N_DIRECTED];

    logic [OWNER_W-1:0] owner_pool [4];
    logic [PAGE_W-1:0]  page_pool  [8];

    int err_cnt        = 0;
    int accepted_items = 0;
    int n_results      = 0;
    int n_lookup       = 0;
    int n_hit          = 0;
    int n_insert       = 0;
    int n_remove_hit   = 0;
    int n_flush        = 0;
    int n_wrap         = 0;
    int n_in_stall     = 0;
    bit pressure_done  = 0;

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #1_000_000;
        $display("%0t: timeout, %0d results still awaited", $time, expected_xlat_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // lowest-index valid slot with matching owner and page, -1 when none
    function automatic int match_slot(logic [OWNER_W-1:0] owner, logic [PAGE_W-1:0] page);
        for (int i = 0; i < N_SLOTS; i++) begin
            if (tlb_valid[i] && tlb_owner[i] == owner && tlb_page[i] == page)
                return i;
        end
        return -1;
    endfunction

    // applies one request to the predictor and returns the translation it gives
    function automatic xlat_t translate_and_update(tlb_req_t r);
        xlat_t res;
        int    slot;
        res = '0;
        case (r.op)
            OP_LOOKUP: begin
                n_lookup++;
                // page is the address above the page offset, low page bits only
                slot = match_slot(r.owner, PAGE_W'(r.addr >> PAGE_SHIFT_DEF));
                if (slot >= 0) begin
                    res.hit   = 1'b1;
                    res.frame = tlb_frame[slot];
                    n_hit++;
                end
            end
            OP_INSERT: begin
                n_insert++;
                // no duplicate check, the victim slot is simply overwritten
                tlb_page[victim_slot]  = r.page;
                tlb_frame[victim_slot] = r.frame;
                tlb_owner[victim_slot] = r.owner;
                tlb_valid[victim_slot] = 1'b1;
                if (victim_slot == N_SLOTS - 1) begin
                    victim_slot = 0;
                    n_wrap++;
                end else begin
                    victim_slot++;
                end
            end
            OP_REMOVE: begin
                slot = match_slot(r.owner, r.page);
                if (slot >= 0) begin
                    tlb_valid[slot] = 1'b0;
                    n_remove_hit++;
                end
            end
            default: begin
                // flush wipes every slot but keeps the victim pointer
                n_flush++;
                for (int i = 0; i < N_SLOTS; i++) begin
                    tlb_page[i]  = '0;
                    tlb_frame[i] = '0;
                    tlb_owner[i] = '0;
                    tlb_valid[i] = 1'b0;
                end
            end
        endcase
        return res;
    endfunction

    // random request, mostly drawn from small pools or live slots so that hits happen
    function automatic tlb_req_t random_req();
        tlb_req_t    r;
        int unsigned pick;
        int unsigned k;
        logic [31:0] rnd;
        pick = $urandom_range(0, 99);
        r.op = (pick < 46) ? OP_LOOKUP : (pick < 78) ? OP_INSERT :
               (pick < 98) ? OP_REMOVE : OP_FLUSH;
        rnd = $urandom;
        r.addr = rnd;
        rnd = $urandom;
        r.frame = rnd[FRAME_W-1:0];
        rnd = $urandom;
        r.page = rnd[PAGE_W-1:0];
        rnd = $urandom;
        r.owner = rnd[OWNER_W-1:0];
        if ($urandom_range(0, 99) < 85) begin
            r.owner = owner_pool[$urandom_range(0, 3)];
            r.page  = page_pool[$urandom_range(0, 7)];
        end
        k = $urandom_range(0, N_SLOTS - 1);
        if ((r.op == OP_LOOKUP || r.op == OP_REMOVE) && tlb_valid[k]
                && $urandom_range(0, 99) < 60) begin
            r.owner = tlb_owner[k];
            r.page  = tlb_page[k];
        end
        // lookups mostly aim the address at the chosen page, random offset below it
        if (r.op == OP_LOOKUP && $urandom_range(0, 9) != 0)
            r.addr[ADDR_W-1:PAGE_SHIFT_DEF] = r.page;
        r.fixed      = 1'b0;
        r.want_hit   = 1'b0;
        r.want_frame = '0;
        return r;
    endfunction

    // scoreboard: results checked first, then the item taken at the same edge is predicted
    always @(posedge aclk) begin
        xlat_t pred;
        xlat_t exp_x;
        if (aresetn) begin
            if (s_tvalid && !s_tready)
                n_in_stall++;
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_xlat_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with none expected: hit=%0b tdata=%h",
                             $time, m_tuser[0], m_tdata);
                end else begin
                    exp_x = expected_xlat_q.pop_front();
                    if (m_tuser[0] !== exp_x.hit) begin
                        err_cnt++;
                        $display("%0t: hit mismatch: expected %0b actual %0b",
                                 $time, exp_x.hit, m_tuser[0]);
                    end
                    if (m_tdata !== {4'b0, exp_x.frame}) begin
                        err_cnt++;
                        $display("%0t: frame mismatch: expected %h actual %h",
                                 $time, {4'b0, exp_x.frame}, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                accepted_items++;
                pred = translate_and_update(cur_req);
                if (cur_req.fixed)
                    pred = {cur_req.want_hit, cur_req.want_frame};
                expected_xlat_q.push_back(pred);
            end
        end
    end

    // receiver: stall pattern changing in spans, plus one long hold-off to fill the block
    initial begin
        int unsigned mode;
        int unsigned span;
        wait (aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            repeat (span) begin
                @(negedge aclk);
                if (!pressure_done && accepted_items >= PRESSURE_AT) begin
                    // sender keeps offering, so the queue fills and s_tready drops
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                    pressure_done = 1'b1;
                end else begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(0, 3) != 0);
                        2:       m_tready <= ($urandom_range(0, 1) == 1);
                        default: m_tready <= ($urandom_range(0, 4) == 0);
                    endcase
                end
            end
        end
    end

    // reset, directed table, random items, drain and verdict
    initial begin
        tlb_req_t    r;
        int          i;
        int          b;
        int unsigned burst;
        int unsigned gap;
        logic [31:0] rnd;

        for (int k = 0; k < N_SLOTS; k++) begin
            tlb_page[k]  = '0;
            tlb_frame[k] = '0;
            tlb_owner[k] = '0;
            tlb_valid[k] = 1'b0;
        end
        victim_slot = 0;

        // pools hold the extremes plus a few random values
        owner_pool[0] = '0;
        owner_pool[1] = '1;
        for (int k = 2; k < 4; k++) begin
            rnd = $urandom;
            owner_pool[k] = rnd[OWNER_W-1:0];
        end
        page_pool[0] = '0;
        page_pool[1] = '1;
        for (int k = 2; k < 8; k++) begin
            rnd = $urandom;
            page_pool[k] = rnd[PAGE_W-1:0];
        end

        // op, owner, address, page, frame, typed, hit, frame out
        directed_tbl = '{
            // empty after reset: lookup misses and remove finds nothing
            '{OP_LOOKUP, 16'h0000, 32'h0000_0000, 20'h00000, 20'h00000, 1, 0, 20'h00000},
            '{OP_REMOVE, 16'h0000, 32'h0000_0000, 20'h00000, 20'h00000, 1, 0, 20'h00000},
            // all-ones entry and lookups that hit it, miss on owner, miss on page
            '{OP_INSERT, 16'hFFFF, 32'h0000_0000, 20'hFFFFF, 20'hFFFFF, 1, 0, 20'h00000},
            '{OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 20'h00000, 20'h00000, 1, 1, 20'hFFFFF},
            '{OP_LOOKUP, 16'hFFFE, 32'hFFFF_FFFF, 20'h00000, 20'h00000, 1, 0, 20'h00000},
            '{OP_LOOKUP, 16'hFFFF, 32'hFFFF_EFFF, 20'hFFFFF, 20'hFFFFF, 1, 0, 20'h00000},
            // unused fields held at ones should be ignored
            '{OP_INSERT, 16'h0000, 32'hFFFF_FFFF, 20'h00000, 20'h12345, 1, 0, 20'h00000},
            '{OP_LOOKUP, 16'h0000, 32'h0000_0FFF, 20'hFFFFF, 20'hFFFFF, 1, 1, 20'h12345},
            // duplicate insert: lowest slot wins, remove takes the lowest one out
            '{OP_INSERT, 16'h0000, 32'h0000_0000, 20'h00000, 20'hABCDE, 1, 0, 20'h00000},
            '{OP_LOOKUP, 16'h0000, 32'h0000_0000, 20'h00000, 20'h00000, 0, 0, 20'h00000},
            '{OP_REMOVE, 16'h0000, 32'h0000_0000, 20'h00000, 20'h00000, 1, 0, 20'h00000},
            '{OP_LOOKUP, 16'h0000, 32'h0000_0123, 20'h00000, 20'h00000, 0, 0, 20'h00000},
            '{OP_REMOVE, 16'h0005, 32'h0000_0000, 20'h00007, 20'h00000, 1, 0, 20'h00000},
            // alternating bit patterns
            '{OP_INSERT, 16'hAAAA, 32'h0000_0000, 20'h55555, 20'hAAAAA, 1, 0, 20'h00000},
            '{OP_INSERT, 16'h5555, 32'h0000_0000, 20'hAAAAA, 20'h55555, 1, 0, 20'h00000},
            '{OP_LOOKUP, 16'hAAAA, 32'h5555_5AAA, 20'h00000, 20'h00000, 0, 0, 20'h00000},
            '{OP_LOOKUP, 16'h5555, 32'hAAAA_A555, 20'h00000, 20'h00000, 0, 0, 20'h00000},
            '{OP_LOOKUP, 16'h0000, 32'h8000_0000, 20'h00000, 20'h00000, 0, 0, 20'h00000},
            // flush, then everything misses, victim pointer carries on
            '{OP_FLUSH,  16'h1234, 32'h89AB_CDEF, 20'h13579, 20'h2468A, 1, 0, 20'h00000},
            '{OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 20'h00000, 20'h00000, 1, 0, 20'h00000},
            '{OP_LOOKUP, 16'hAAAA, 32'h5555_5000, 20'h00000, 20'h00000, 1, 0, 20'h00000},
            '{OP_INSERT, 16'h0001, 32'h0000_0000, 20'h00001, 20'h00001, 1, 0, 20'h00000},
            '{OP_LOOKUP, 16'h0001, 32'h0000_1000, 20'h00000, 20'h00000, 0, 0, 20'h00000},
            '{OP_REMOVE, 16'hFFFF, 32'h0000_0000, 20'hFFFFF, 20'h00000, 1, 0, 20'h00000}
        };

        // reset held at first, then released on a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // sender: bursts of items with random gaps, a third of the gaps empty
        i = 0;
        while (i < N_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (b = 0; b < burst && i < N_ITEMS; b++) begin
                @(negedge aclk);
                r = (i < N_DIRECTED) ? directed_tbl[i] : random_req();
                cur_req  <= r;
                s_tvalid <= 1'b1;
                s_tuser  <= r.op;
                s_tdata  <= {r.frame, r.page, r.addr, r.owner};
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
                i++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // drain, then keep watching to catch stray results
        while (expected_xlat_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d items, %0d results: %0d lookups (%0d hits), %0d inserts",
                 accepted_items, n_results, n_lookup, n_hit, n_insert);
        $display("  %0d removes that hit, %0d flushes, %0d victim wraps, %0d input stall cycles",
                 n_remove_hit, n_flush, n_wrap, n_in_stall);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
